@@ rtl/rbf_pkg.sv @@
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types and constants of the ring buffer FIFO: ring geometry, the
// operation codes, the sequencer states and the pointer-unit result bundle.
// ----------------------------------------------------------------------------
package rbf_pkg;

   // ring geometry
   localparam int DEPTH      = 16;
   localparam int WIDTH      = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SLOT_MIN   = 2;
   localparam int SLOT_RESET = 16;

   // interface field widths
   localparam int OP_W     = 3;
   localparam int AMOUNT_W = 8;
   localparam int DATA_W   = 32;
   localparam int LEVEL_W  = 4;
   localparam int CSR_W    = 5;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH     = 3'd0,
      OP_POP      = 3'd1,
      OP_PEEK     = 3'd2,
      OP_SKIP     = 3'd3,
      OP_CLR_TAIL = 3'd4,
      OP_CLR_HEAD = 3'd5,
      OP_SEEK     = 3'd6
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   // result of one operation from the pointer unit
   typedef struct packed {
      logic               ok;
      logic [LEVEL_W-1:0] skipped;
      logic               empty;
      logic               full;
      logic [LEVEL_W-1:0] level;
      logic               mem_rd;
      logic               mem_wr;
      logic [IDX_W-1:0]   mem_addr;
   } ptr_result_type;

endpackage

@@ rtl/rbf_ram.sv @@
// ----------------------------------------------------------------------------
// rbf_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module rbf_ram #(
   parameter int RAM_WIDTH = 32,
   parameter int RAM_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic                         rd_en,
   input  logic [$clog2(RAM_DEPTH)-1:0] addr,
   input  logic [RAM_WIDTH-1:0]         wdata,
   output logic [RAM_WIDTH-1:0]         rdata
);

   logic [RAM_WIDTH-1:0] mem_ff [RAM_DEPTH];
   logic [RAM_WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/rbf_ptr.sv @@
// ----------------------------------------------------------------------------
// rbf_ptr
// Head/tail pointers and ring size register. Decodes one operation, works
// out the new pointers, the memory access and the status after the update.
// ----------------------------------------------------------------------------
module rbf_ptr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cfg_we,
   input  logic [rbf_pkg::CSR_W-1:0]     cfg_data,
   input  logic                          step,
   input  logic [rbf_pkg::OP_W-1:0]      op,
   input  logic [rbf_pkg::AMOUNT_W-1:0]  amount,
   output rbf_pkg::ptr_result_type       result
);
   import rbf_pkg::*;

   logic [CSR_W-1:0] slot_count_ff;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] ring_n;
   logic [CNT_W-1:0] lvl_cur;
   logic [CNT_W-1:0] lvl_new;
   logic [CNT_W-1:0] skip_k;
   logic             seek_hit;

   // entries between head and tail on a ring of n slots
   function automatic logic [CNT_W-1:0] fill_of(input logic [IDX_W-1:0] h,
                                                input logic [IDX_W-1:0] t,
                                                input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] hx;
      logic [CNT_W-1:0] tx;
      hx = CNT_W'(h);
      tx = CNT_W'(t);
      if (tx >= hx) begin
         fill_of = tx - hx;
      end else begin
         fill_of = tx + n - hx;
      end
   endfunction

   // (a + b) mod n for a < n, b < n
   function automatic logic [IDX_W-1:0] wrap_of(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b,
                                                input logic [CNT_W-1:0] n);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
      if (s >= (CNT_W+1)'(n)) begin
         s = s - (CNT_W+1)'(n);
      end
      wrap_of = s[IDX_W-1:0];
   endfunction

   // clamp the register to the usable ring size
   always_comb begin
      if (slot_count_ff < CSR_W'(SLOT_MIN)) begin
         ring_n = CNT_W'(SLOT_MIN);
      end else if (CNT_W'(slot_count_ff) > CNT_W'(DEPTH)) begin
         ring_n = CNT_W'(DEPTH);
      end else begin
         ring_n = CNT_W'(slot_count_ff);
      end
   end

   assign lvl_cur  = fill_of(head_ff, tail_ff, ring_n);
   assign seek_hit = amount < AMOUNT_W'(lvl_cur);
   assign skip_k   = seek_hit ? CNT_W'(amount) : lvl_cur;

   // operation decode
   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      result          = '0;
      result.mem_addr = head_ff;
      unique case (op_type'(op)) inside
         OP_PUSH: begin
            if (lvl_cur < ring_n - CNT_W'(1)) begin
               result.ok       = 1'b1;
               result.mem_wr   = 1'b1;
               result.mem_addr = tail_ff;
               tail_in         = wrap_of(tail_ff, CNT_W'(1), ring_n);
            end
         end
         OP_POP, OP_PEEK: begin
            if (lvl_cur != '0) begin
               result.ok     = 1'b1;
               result.mem_rd = 1'b1;
               if (op_type'(op) == OP_POP) begin
                  head_in = wrap_of(head_ff, CNT_W'(1), ring_n);
               end
            end
         end
         OP_SKIP: begin
            result.ok      = 1'b1;
            result.skipped = LEVEL_W'(skip_k);
            head_in        = wrap_of(head_ff, skip_k, ring_n);
         end
         OP_CLR_TAIL: begin
            result.ok = 1'b1;
            tail_in   = head_ff;
         end
         OP_CLR_HEAD: begin
            result.ok = 1'b1;
            head_in   = tail_ff;
         end
         OP_SEEK: begin
            if (seek_hit) begin
               result.ok       = 1'b1;
               result.mem_rd   = 1'b1;
               result.mem_addr = wrap_of(head_ff, CNT_W'(amount), ring_n);
            end
         end
         default: begin
         end
      endcase
      lvl_new      = fill_of(head_in, tail_in, ring_n);
      result.level = LEVEL_W'(lvl_new);
      result.empty = lvl_new == '0;
      result.full  = lvl_new == ring_n - CNT_W'(1);
   end

   // pointer and ring size registers; a size write empties the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= CSR_W'(SLOT_RESET);
         head_ff       <= '0;
         tail_ff       <= '0;
      end else if (cfg_we) begin
         slot_count_ff <= cfg_data;
         head_ff       <= '0;
         tail_ff       <= '0;
      end else if (step) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

endmodule

@@ rtl/ring_buffer_fifo.sv @@
// ----------------------------------------------------------------------------
// ring_buffer_fifo
// Circular FIFO with one slot kept empty: push, pop, peek, skip, clears and
// seek. Slots live in a single-port RAM; pointers in a small control unit.
// Response: push, skip, clears and failed reads: result valid in the cycle after the
//   request transfer; pop, peek, seek that hit: slot RAM read, then the read state.
// Throughput: 1 item per cycle while rsp_tready holds; a slot RAM read holds off new
//   requests through the read state, bounded by its single port with registered read.
// Reset: head and tail to 0, ring size 16; slot RAM contents are not cleared.
// ----------------------------------------------------------------------------
module ring_buffer_fifo (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [39:0]                   req_tdata,  // write_data[31:0], amount[39:32]
   input  logic [rbf_pkg::OP_W-1:0]      req_tuser,  // op[2:0]
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [47:0]                   rsp_tdata,  // ok[0], read_data[32:1],
                                                     // skipped[36:33], empty_res[37],
                                                     // full_res[38], level[42:39]
   // ring size register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rbf_pkg::CSR_W-1:0]     csr_wdata
);
   import rbf_pkg::*;

   state_type            state_ff, state_in;
   ptr_result_type       res;
   logic                 req_xfer;
   logic                 csr_xfer;
   logic [WIDTH-1:0]     ram_rdata;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 ok_ff;
   logic [DATA_W-1:0]    read_data_ff;
   logic [LEVEL_W-1:0]   skipped_ff;
   logic                 empty_ff;
   logic                 full_ff;
   logic [LEVEL_W-1:0]   level_ff;

   assign csr_ready  = 1'b1;
   assign csr_xfer   = csr_valid & csr_ready;
   assign req_tready = (state_ff == ST_IDLE) & (~rsp_valid_ff | rsp_tready);
   assign req_xfer   = req_tvalid & req_tready;

   // pointer unit
   rbf_ptr u_ptr (
      .clock    (clock),
      .reset    (reset),
      .cfg_we   (csr_xfer),
      .cfg_data (csr_wdata),
      .step     (req_xfer),
      .op       (req_tuser),
      .amount   (req_tdata[39:32]),
      .result   (res)
   );

   // slot storage
   rbf_ram #(
      .RAM_WIDTH (WIDTH),
      .RAM_DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .wr_en (req_xfer & res.mem_wr),
      .rd_en (req_xfer & res.mem_rd),
      .addr  (res.mem_addr),
      .wdata (req_tdata[WIDTH-1:0]),
      .rdata (ram_rdata)
   );

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and response valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (res.mem_rd) begin
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ok_ff        <= res.ok;
         skipped_ff   <= res.skipped;
         empty_ff     <= res.empty;
         full_ff      <= res.full;
         level_ff     <= res.level;
         read_data_ff <= '0;
      end else if (state_ff == ST_READ) begin
         read_data_ff <= DATA_W'(ram_rdata);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, level_ff, full_ff, empty_ff, skipped_ff, read_data_ff, ok_ff};

   // checks
   a_read_no_rsp : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !rsp_valid_ff)
      else $error("response valid while slot read in flight");

   a_read_seq : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && res.mem_rd) |=> (state_ff == ST_READ && !req_tready))
      else $error("slot read did not enter read state");

   a_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(empty_ff && full_ff))
      else $error("queue reported both empty and full");

endmodule
